FILE: rtl/mwr_pkg.sv
// Package for the Microwire EEPROM read master: item types, sequencer phases
// and serial framing constants. No dependencies.
`default_nettype none

package mwr_pkg;

   localparam int DATA_BITS = 16;

   // read cycles include the leading dummy zero; two ticks per cycle
   localparam logic [5:0] READ_LEN   = 6'(2 * (DATA_BITS + 1));
   localparam logic [5:0] CMD_LEN    = 6'd6;
   localparam logic [5:0] SELECT_LEN = 6'd1;
   localparam logic [5:0] DESEL_LEN  = 6'd3;

   // start bit and READ opcode, sent MSB first
   localparam logic [2:0] OPCODE = 3'b110;

   localparam logic [3:0] ADDRESS_BITS_RESET = 4'd6;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SELECT = 3'd1,
      PH_CMD    = 3'd2,
      PH_ADDR   = 3'd3,
      PH_READ   = 3'd4,
      PH_DESEL  = 3'd5
   } phase_type;

   typedef struct packed {
      logic       start_request;
      logic [7:0] start_address;
      logic [8:0] word_count;
      logic       data_in;
   } req_type;

   typedef struct packed {
      logic        chip_select;
      logic        serial_clock;
      logic        data_out;
      logic        word_valid;
      logic [15:0] word_data;
      logic [7:0]  word_offset;
      logic        last_word;
      logic        busy_res;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/mwr_sequencer.sv
// Tick sequencer: burst state registers and the per-tick pin/word logic.
// Depends on mwr_pkg.
`default_nettype none

module mwr_sequencer (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire mwr_pkg::req_type item,
   input  wire logic [3:0]      address_bits,
   output mwr_pkg::rsp_type     result
);

   mwr_pkg::phase_type                phase_ff, phase_in;
   logic [5:0]                        bit_step_ff, bit_step_in;
   logic [mwr_pkg::DATA_BITS-1:0]     shift_word_ff, shift_word_in;
   logic [7:0]                        address_ff, address_in;
   logic [8:0]                        words_left_ff, words_left_in;
   logic [7:0]                        offset_ff, offset_in;

   logic                              start;
   mwr_pkg::phase_type                e_phase, next_phase;
   logic [5:0]                        e_step, step_inc, len;
   logic [4:0]                        pos, ab5, idx;
   logic [1:0]                        opos;

   always_comb begin
      start = (phase_ff == mwr_pkg::PH_IDLE) && item.start_request && (item.word_count != 9'd0);

      e_phase       = start ? mwr_pkg::PH_SELECT : phase_ff;
      e_step        = start ? 6'd0 : bit_step_ff;
      address_in    = start ? item.start_address : address_ff;
      words_left_in = start ? item.word_count : words_left_ff;
      offset_in     = start ? 8'd0 : offset_ff;

      phase_in      = e_phase;
      bit_step_in   = e_step;
      shift_word_in = shift_word_ff;
      result        = '0;
      len           = 6'd0;
      next_phase    = mwr_pkg::PH_IDLE;
      step_inc      = e_step + 6'd1;
      pos           = e_step[5:1];
      ab5           = {1'b0, address_bits};
      idx           = 5'd0;
      opos          = (e_step[2:1] > 2'd2) ? 2'd2 : e_step[2:1];

      case (e_phase)
         mwr_pkg::PH_SELECT: begin
            result.chip_select  = 1'b1;
            result.serial_clock = 1'b1;
            shift_word_in       = '0;
            len                 = mwr_pkg::SELECT_LEN;
            next_phase          = mwr_pkg::PH_CMD;
         end
         mwr_pkg::PH_CMD: begin
            result.chip_select  = 1'b1;
            result.serial_clock = e_step[0];
            result.data_out     = mwr_pkg::OPCODE[2'd2 - opos];
            len                 = mwr_pkg::CMD_LEN;
            next_phase          = (address_bits != 4'd0) ? mwr_pkg::PH_ADDR : mwr_pkg::PH_READ;
         end
         mwr_pkg::PH_ADDR: begin
            // MSB first; bits above bit 7 of the address go out as zero
            idx                 = (pos < ab5) ? (ab5 - 5'd1 - pos) : 5'd0;
            result.chip_select  = 1'b1;
            result.serial_clock = e_step[0];
            result.data_out     = (idx[4:3] == 2'd0) ? address_in[idx[2:0]] : 1'b0;
            len                 = {1'b0, address_bits, 1'b0};
            next_phase          = mwr_pkg::PH_READ;
         end
         mwr_pkg::PH_READ: begin
            result.chip_select  = 1'b1;
            result.serial_clock = e_step[0];
            len                 = mwr_pkg::READ_LEN;
            next_phase          = mwr_pkg::PH_DESEL;
            if (!e_step[0]) begin
               shift_word_in = {shift_word_ff[mwr_pkg::DATA_BITS-2:0], item.data_in};
            end else if (step_inc == mwr_pkg::READ_LEN) begin
               result.word_valid  = 1'b1;
               result.word_data   = 16'(shift_word_ff);
               result.word_offset = offset_in;
               result.last_word   = (words_left_in == 9'd1);
               address_in         = address_in + 8'd1;
               offset_in          = offset_in + 8'd1;
               words_left_in      = words_left_in - 9'd1;
            end
         end
         mwr_pkg::PH_DESEL: begin
            result.serial_clock = (e_step == 6'd1);
            len                 = mwr_pkg::DESEL_LEN;
            next_phase          = (words_left_in != 9'd0) ? mwr_pkg::PH_SELECT : mwr_pkg::PH_IDLE;
         end
         default: begin
            phase_in    = mwr_pkg::PH_IDLE;
            bit_step_in = 6'd0;
         end
      endcase

      if (phase_in != mwr_pkg::PH_IDLE) begin
         result.busy_res = 1'b1;
         if (step_inc >= len) begin
            phase_in    = next_phase;
            bit_step_in = 6'd0;
         end else begin
            bit_step_in = step_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= mwr_pkg::PH_IDLE;
         bit_step_ff   <= 6'd0;
         shift_word_ff <= '0;
         address_ff    <= 8'd0;
         words_left_ff <= 9'd0;
         offset_ff     <= 8'd0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         bit_step_ff   <= bit_step_in;
         shift_word_ff <= shift_word_in;
         address_ff    <= address_in;
         words_left_ff <= words_left_in;
         offset_ff     <= offset_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/microwire_eeprom_read_master_core.sv
// Microwire EEPROM read master top level: input item register, tick
// sequencer, result register, address-width register. Depends on mwr_pkg.
//
// Each input item is one half-bit tick of the serial clock and yields exactly
// one result item with the pin levels for that tick, plus a completed word on
// the clock-high tick of the last read cycle. One item is taken every cycle
// while the result is not stalled; an accepted item is held in the input
// register, and the sequencer's state update loads its result item into the
// result register. A stalled result holds the input register and stalls
// the input. A start request is honored only when idle and with a non-zero
// count; its tick is already the select tick. A word costs 1 + 6 +
// 2*address_bits + 34 + 3 ticks. address_bits may be written only while no
// item is in flight.
`default_nettype none

module microwire_eeprom_read_master_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mwr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mwr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [3:0]       csr_data
);

   logic              in_valid_ff;
   mwr_pkg::req_type  in_data_ff;
   logic              out_valid_ff;
   mwr_pkg::rsp_type  out_data_ff;
   logic [3:0]        address_bits_ff;
   logic              out_adv, fire;
   mwr_pkg::rsp_type  result;

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_adv;
   assign req_stall = in_valid_ff && !out_adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_bits_ff <= mwr_pkg::ADDRESS_BITS_RESET;
      end else if (csr_valid && csr_ready) begin
         address_bits_ff <= csr_data;
      end
   end

   mwr_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (in_data_ff),
      .address_bits (address_bits_ff),
      .result       (result)
   );

endmodule

`default_nettype wire

FILE: rtl/mwr_checker.sv
// Port-level checks for the Microwire read master, bound to the top level.
// Depends on mwr_pkg and microwire_eeprom_read_master_core.
`default_nettype none

module mwr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire mwr_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire mwr_pkg::rsp_type rsp_data,
   input wire logic             csr_valid,
   input wire logic             csr_ready,
   input wire logic [3:0]       csr_data
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // idle ticks drive every pin and word field low
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> rsp_data == '0)
      else $error("idle tick with nonzero outputs");

   // words land on a selected clock-high read tick
   a_word_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.word_valid |->
         rsp_data.chip_select && rsp_data.serial_clock && !rsp_data.data_out)
      else $error("word presented outside a read clock-high tick");

   a_word_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.word_valid |->
         rsp_data.word_data == 16'd0 && rsp_data.word_offset == 8'd0 && !rsp_data.last_word)
      else $error("word fields set without a word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item right after reset");

endmodule

bind microwire_eeprom_read_master_core mwr_checker u_mwr_checker (.*);

`default_nettype wire

FILE: verif/mwr_read_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Microwire EEPROM read master: follows the item, result and
// register channels, predicts every result item and compares it field by field.
// Depends on mwr_pkg.
`default_nettype none

module mwr_read_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire mwr_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire mwr_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [3:0]       csr_data,
   output int                    fail_count,
   output int                    pending
);

   // start bit then READ opcode, first sent bit on the left
   localparam logic [2:0] START_AND_READ = 3'b110;
   localparam int READ_TICKS = 2 * (mwr_pkg::DATA_BITS + 1);

   mwr_pkg::phase_type seq_phase;
   logic [5:0]         tick_step;
   logic [15:0]        shift_in;
   logic [7:0]         word_address;
   logic [8:0]         words_to_go;
   logic [7:0]         word_index;
   logic [3:0]         address_width;
   mwr_pkg::rsp_type   pin_levels_due[$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // one half-bit tick of the sequencer
   function automatic mwr_pkg::rsp_type next_pin_levels(input mwr_pkg::req_type item);
      mwr_pkg::rsp_type   r;
      mwr_pkg::phase_type after;
      int                 span;
      int                 pos;
      int                 idx;
      int                 width;
      r = '0;
      after = mwr_pkg::PH_IDLE;
      span = 0;
      width = int'(address_width);
      pos = int'(tick_step) >> 1;
      if (seq_phase == mwr_pkg::PH_IDLE && item.start_request &&
          item.word_count != 9'd0) begin
         word_address = item.start_address;
         words_to_go = item.word_count;
         word_index = '0;
         seq_phase = mwr_pkg::PH_SELECT;
         tick_step = '0;
      end
      case (seq_phase)
         mwr_pkg::PH_SELECT: begin
            r.chip_select = 1'b1;
            r.serial_clock = 1'b1;
            shift_in = '0;
            span = 1;
            after = mwr_pkg::PH_CMD;
         end
         mwr_pkg::PH_CMD: begin
            r.chip_select = 1'b1;
            r.serial_clock = tick_step[0];
            r.data_out = START_AND_READ[2 - ((pos < 3) ? pos : 2)];
            span = 6;
            after = (width != 0) ? mwr_pkg::PH_ADDR : mwr_pkg::PH_READ;
         end
         mwr_pkg::PH_ADDR: begin
            r.chip_select = 1'b1;
            r.serial_clock = tick_step[0];
            idx = (pos < width) ? width - 1 - pos : 0;
            // widths above eight send zeros for the missing high bits
            r.data_out = (idx < 8) ? word_address[idx] : 1'b0;
            span = 2 * width;
            after = mwr_pkg::PH_READ;
         end
         mwr_pkg::PH_READ: begin
            r.chip_select = 1'b1;
            r.serial_clock = tick_step[0];
            span = READ_TICKS;
            after = mwr_pkg::PH_DESEL;
            if (!tick_step[0]) begin
               shift_in = {shift_in[14:0], item.data_in};
            end else if (int'(tick_step) + 1 == span) begin
               r.word_valid = 1'b1;
               r.word_data = shift_in;
               r.word_offset = word_index;
               r.last_word = (words_to_go == 9'd1);
               word_address = word_address + 8'd1;
               word_index = word_index + 8'd1;
               words_to_go = words_to_go - 9'd1;
            end
         end
         mwr_pkg::PH_DESEL: begin
            r.serial_clock = (tick_step == 6'd1);
            span = 3;
            after = (words_to_go != 9'd0) ? mwr_pkg::PH_SELECT : mwr_pkg::PH_IDLE;
         end
         default: begin
            seq_phase = mwr_pkg::PH_IDLE;
            tick_step = '0;
         end
      endcase
      if (seq_phase != mwr_pkg::PH_IDLE) begin
         r.busy_res = 1'b1;
         tick_step = tick_step + 6'd1;
         if (int'(tick_step) >= span) begin
            seq_phase = after;
            tick_step = '0;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      mwr_pkg::rsp_type want;
      if (reset) begin
         seq_phase = mwr_pkg::PH_IDLE;
         tick_step = '0;
         shift_in = '0;
         word_address = '0;
         words_to_go = '0;
         word_index = '0;
         address_width = mwr_pkg::ADDRESS_BITS_RESET;
         pin_levels_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            address_width = csr_data;
         if (req_valid && !req_stall)
            pin_levels_due.push_back(next_pin_levels(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pin_levels_due.size() == 0) begin
               fail_count++;
               $display("%0t: result item expected none, got %h", $time, rsp_data);
            end else begin
               want = pin_levels_due.pop_front();
               check_field("chip_select", 16'(want.chip_select),
                           16'(rsp_data.chip_select));
               check_field("serial_clock", 16'(want.serial_clock),
                           16'(rsp_data.serial_clock));
               check_field("data_out", 16'(want.data_out), 16'(rsp_data.data_out));
               check_field("word_valid", 16'(want.word_valid),
                           16'(rsp_data.word_valid));
               check_field("word_data", want.word_data, rsp_data.word_data);
               check_field("word_offset", 16'(want.word_offset),
                           16'(rsp_data.word_offset));
               check_field("last_word", 16'(want.last_word), 16'(rsp_data.last_word));
               check_field("busy_res", 16'(want.busy_res), 16'(rsp_data.busy_res));
            end
         end
      end
      pending = pin_levels_due.size();
   end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the Microwire EEPROM read master test: clock, reset, tick stimulus,
// result back-pressure and address-width writes. Depends on mwr_pkg, the core
// and mwr_read_checker.
`default_nettype none

module testbench;

   // ~2.6k ticks at most, each with its worst-case idle gap and stall, taken ~10x
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int RANDOM_TICKS = 300;
   localparam int WORD_TICKS_FIXED = 1 + 6 + 2 * (mwr_pkg::DATA_BITS + 1) + 3;
   localparam int FILL_ZERO = 0;
   localparam int FILL_ONE = 1;
   localparam int FILL_RANDOM = 2;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mwr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mwr_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [3:0]       csr_data = mwr_pkg::ADDRESS_BITS_RESET;

   int fail_count;
   int pending;
   int cycles = 0;
   int address_width = int'(mwr_pkg::ADDRESS_BITS_RESET);
   int burst_ticks = 0;
   int stall_left = 0;

   always #6 clock = ~clock;

   microwire_eeprom_read_master_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   mwr_read_checker i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending(pending)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // result back-pressure: quiet stretches, short stalls, now and then a long one
   always @(posedge clock) begin
      int roll;
      if (stall_left != 0) begin
         stall_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(100, 400);
         end else if (roll < 55) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(0, 30);
         end else if (roll < 94) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 94)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // present one tick item and hold it until taken, then maybe idle
   task automatic send_tick(input mwr_pkg::req_type item);
      int gap;
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // request tick plus every following tick until the burst has ended
   task automatic run_burst(input int first, input int count, input int fill,
                            input bit chatter);
      mwr_pkg::req_type item;
      int               ticks;
      ticks = count * (WORD_TICKS_FIXED + 2 * address_width);
      for (int t = 0; t < ticks; t++) begin
         item = '0;
         item.start_address = 8'($urandom_range(0, 255));
         item.word_count = 9'($urandom_range(0, 256));
         if (t == 0) begin
            item.start_request = 1'b1;
            item.start_address = 8'(first);
            item.word_count = 9'(count);
         end else if (chatter) begin
            // requests while busy must be dropped
            item.start_request = ($urandom_range(0, 3) == 0);
         end
         if (fill == FILL_ZERO)
            item.data_in = 1'b0;
         else if (fill == FILL_ONE)
            item.data_in = 1'b1;
         else
            item.data_in = 1'($urandom_range(0, 1));
         send_tick(item);
         burst_ticks++;
      end
   endtask

   // an item that starts nothing: no request, or a request for zero words
   task automatic send_ignored(input bit with_request);
      mwr_pkg::req_type item;
      item.start_request = with_request;
      item.start_address = 8'($urandom_range(0, 255));
      item.word_count = with_request ? 9'd0 : 9'($urandom_range(1, 256));
      item.data_in = 1'($urandom_range(0, 1));
      send_tick(item);
   endtask

   // register write only once every result item has come back
   task automatic set_address_width(input int width);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      csr_data <= 4'(width);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      address_width = width;
   endtask

   initial begin
      int roll;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_ignored(1'b0);
      send_ignored(1'b1);
      run_burst(0, 1, FILL_ZERO, 1'b0);
      run_burst(255, 3, FILL_ONE, 1'b1);   // address wraps past 255
      run_burst($urandom_range(0, 255), 2, FILL_RANDOM, 1'b0);
      set_address_width(8);
      run_burst(255, 2, FILL_RANDOM, 1'b0);
      run_burst(0, 1, FILL_ONE, 1'b0);
      set_address_width(7);
      run_burst(8'haa, 1, FILL_RANDOM, 1'b0);
      set_address_width(0);                // read follows the opcode directly
      run_burst(8'h55, 2, FILL_RANDOM, 1'b1);
      set_address_width(15);               // high address bits go out as zero
      run_burst(255, 2, FILL_RANDOM, 1'b0);
      set_address_width(9);
      run_burst(128, 1, FILL_RANDOM, 1'b0);
      set_address_width(6);
      run_burst($urandom_range(0, 255), 4, FILL_RANDOM, 1'b1);

      burst_ticks = 0;
      while (burst_ticks < RANDOM_TICKS) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            if ($urandom_range(0, 3) == 0)
               set_address_width($urandom_range(0, 15));
            else
               set_address_width($urandom_range(6, 8));
         end else if (roll < 20) begin
            send_ignored(1'($urandom_range(0, 1)));
         end else begin
            run_burst($urandom_range(0, 255),
                      (roll < 90) ? $urandom_range(1, 3) : $urandom_range(4, 12),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(FILL_ZERO, FILL_ONE)
                                                  : FILL_RANDOM,
                      ($urandom_range(0, 2) == 0));
         end
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/mwr_pkg.sv
rtl/mwr_sequencer.sv
rtl/microwire_eeprom_read_master_core.sv
rtl/mwr_checker.sv
verif/mwr_read_checker.sv
verif/testbench.sv
